// ===== rtl/apds_pkg.sv =====
// Package for the audio period DMA sequencer.
// Holds command, register and result codes, the configuration and plan types.
// No dependencies.
package apds_pkg;

    // Event commands carried on the input side
    typedef enum logic [2:0] {
        CMD_IRQ        = 3'd0,
        CMD_PLAY_START = 3'd1,
        CMD_PLAY_STOP  = 3'd2,
        CMD_CAP_START  = 3'd3,
        CMD_CAP_STOP   = 3'd4
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PLAY_BASE   = 3'd0,
        CFG_PLAY_PERIOD = 3'd1,
        CFG_PLAY_BUFFER = 3'd2,
        CFG_CAP_BASE    = 3'd3,
        CFG_CAP_PERIOD  = 3'd4,
        CFG_CAP_BUFFER  = 3'd5,
        CFG_CAP_CHAN    = 3'd6
    } cfg_index_t;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_PLAY  = 2'd1;
    localparam logic [1:0] KIND_CAP   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Device register codes
    localparam logic [2:0] REG_IRQ      = 3'd0;
    localparam logic [2:0] REG_B1_ADDR  = 3'd1;
    localparam logic [2:0] REG_B1_SIZE  = 3'd2;
    localparam logic [2:0] REG_B2_ADDR  = 3'd3;
    localparam logic [2:0] REG_B2_SIZE  = 3'd4;
    localparam logic [2:0] REG_RD_ADDR  = 3'd5;
    localparam logic [2:0] REG_RD_START = 3'd6;

    // Status and irq mask bits
    localparam logic [2:0] PLAY_BITS = 3'b011;
    localparam logic [2:0] CAP_BIT   = 3'b100;
    localparam int         STAT_B1   = 0;
    localparam int         STAT_CAP  = 2;

    // Widths
    localparam int ADDR_W  = 48;
    localparam int PTR_W   = 14;
    localparam int PPER_W  = 14;
    localparam int FRM_W   = 15;
    localparam int RING_W  = 17;   // holds any ring length limit up to 65536
    localparam int RSTART_W = FRM_W + 3;

    // Result slots, emitted in ascending order
    localparam int SLOT_IRQ_FIRST = 0;
    localparam int SLOT_NONE      = 1;
    localparam int SLOT_PLAY_ADDR = 2;
    localparam int SLOT_PLAY_SIZE = 3;
    localparam int SLOT_RD_ADDR   = 4;
    localparam int SLOT_RD_START  = 5;
    localparam int SLOT_IRQ_FINAL = 6;
    localparam int SLOT_PLAY_NOTE = 7;
    localparam int SLOT_CAP_NOTE  = 8;
    localparam int NSLOTS         = 9;
    localparam int SLOT_W         = 4;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [ADDR_W-1:0] play_base;
        logic [PPER_W-1:0] play_period;
        logic [FRM_W-1:0]  play_buffer;
        logic [ADDR_W-1:0] cap_base;
        logic [FRM_W-1:0]  cap_period;
        logic [FRM_W-1:0]  cap_buffer;
        logic [1:0]        cap_chan;
    } cfg_t;

    // One classified event, as handed from front to back
    typedef struct packed {
        logic [NSLOTS-1:0] slots;
        logic [2:0]        irq_first;
        logic [2:0]        irq_final;
        logic              play_buf2;
        logic [PTR_W-1:0]  play_ptr;
        logic [PPER_W-1:0] play_fr;
        logic [PTR_W-1:0]  cap_ptr;
        logic [FRM_W-1:0]  cap_fr;
        logic [PTR_W-1:0]  play_pos;
        logic [PTR_W-1:0]  cap_pos;
    } plan_t;

endpackage

// ===== rtl/apds_cfg_regs.sv =====
// Configuration register file of the audio period DMA sequencer.
// Depends on apds_pkg.
module apds_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data,
    output apds_pkg::cfg_t    cfg
);

    // everything clears, except capture channels which come up as stereo
    localparam apds_pkg::cfg_t CFG_RESET = '{
        play_base:   '0,
        play_period: '0,
        play_buffer: '0,
        cap_base:    '0,
        cap_period:  '0,
        cap_buffer:  '0,
        cap_chan:    2'd2
    };

    apds_pkg::cfg_t cfg_reg;
    apds_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode, each write truncated to its field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (apds_pkg::cfg_index_t'(cfg_index))
                apds_pkg::CFG_PLAY_BASE:   cfg_next.play_base   = cfg_data;
                apds_pkg::CFG_PLAY_PERIOD: cfg_next.play_period =
                    cfg_data[apds_pkg::PPER_W-1:0];
                apds_pkg::CFG_PLAY_BUFFER: cfg_next.play_buffer =
                    cfg_data[apds_pkg::FRM_W-1:0];
                apds_pkg::CFG_CAP_BASE:    cfg_next.cap_base    = cfg_data;
                apds_pkg::CFG_CAP_PERIOD:  cfg_next.cap_period  =
                    cfg_data[apds_pkg::FRM_W-1:0];
                apds_pkg::CFG_CAP_BUFFER:  cfg_next.cap_buffer  =
                    cfg_data[apds_pkg::FRM_W-1:0];
                apds_pkg::CFG_CAP_CHAN:    cfg_next.cap_chan    = cfg_data[1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/apds_front.sv =====
// Front end: accepts events, updates stream state and ring pointers,
// and builds the result plan for each event. Depends on apds_pkg.
module apds_front
#(
    parameter int MAX_RING_FRAMES = 16384
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  apds_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    input  logic [2:0]           in_cmd,
    input  logic [2:0]           in_status,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 q_push,
    output apds_pkg::plan_t      q_plan
);

    localparam int RW = apds_pkg::RING_W;
    localparam logic [RW-1:0] RING_MAX = RW'(MAX_RING_FRAMES);

    logic [2:0]                  mask_reg, mask_next;
    logic                        play_act_reg, play_act_next;
    logic                        cap_act_reg, cap_act_next;
    logic                        priming_reg, priming_next;
    logic [apds_pkg::PTR_W-1:0]  play_ptr_reg, play_ptr_next;
    logic [apds_pkg::PTR_W-1:0]  cap_ptr_reg, cap_ptr_next;
    logic [apds_pkg::PTR_W-1:0]  fill_ptr_reg, fill_ptr_next;

    logic [RW-1:0] p_ring, p_left, p_per, p_fr, p_sum, p_new;
    logic [RW-1:0] c_ring, c_left, c_per, c_fr, c_sum, c_new;
    logic [2:0]    m;
    logic          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // playback chunk: period clamped to the space left before the ring end
    always_comb
    begin
        p_ring = (RW'(cfg.play_buffer) > RING_MAX) ? RING_MAX : RW'(cfg.play_buffer);
        p_left = (p_ring > RW'(play_ptr_reg)) ? p_ring - RW'(play_ptr_reg) : '0;
        p_per  = RW'(cfg.play_period);
        p_fr   = (p_per > p_left) ? p_left : p_per;
        p_sum  = RW'(play_ptr_reg) + p_fr;
        p_new  = (p_sum == p_ring) ? '0 : p_sum;
    end

    // capture chunk, taken from the pointer of the next fill
    always_comb
    begin
        c_ring = (RW'(cfg.cap_buffer) > RING_MAX) ? RING_MAX : RW'(cfg.cap_buffer);
        c_left = (c_ring > RW'(fill_ptr_reg)) ? c_ring - RW'(fill_ptr_reg) : '0;
        c_per  = RW'(cfg.cap_period);
        c_fr   = (c_per > c_left) ? c_left : c_per;
        c_sum  = RW'(fill_ptr_reg) + c_fr;
        c_new  = (c_sum == c_ring) ? '0 : c_sum;
    end

    // event classification and state update
    always_comb
    begin
        mask_next     = mask_reg;
        play_act_next = play_act_reg;
        cap_act_next  = cap_act_reg;
        priming_next  = priming_reg;
        play_ptr_next = play_ptr_reg;
        cap_ptr_next  = cap_ptr_reg;
        fill_ptr_next = fill_ptr_reg;
        q_plan        = '0;
        q_push        = 1'b0;
        m             = mask_reg;
        q_plan.play_ptr = play_ptr_reg;
        q_plan.play_fr  = p_fr[apds_pkg::PPER_W-1:0];
        q_plan.cap_ptr  = fill_ptr_reg;
        q_plan.cap_fr   = c_fr[apds_pkg::FRM_W-1:0];
        if (accept)
        begin
            unique case (apds_pkg::cmd_t'(in_cmd))
                apds_pkg::CMD_IRQ:
                begin
                    q_push = 1'b1;
                    q_plan.slots[apds_pkg::SLOT_IRQ_FIRST] = 1'b1;
                    if (in_status == 3'd0)
                    begin
                        q_plan.slots[apds_pkg::SLOT_NONE] = 1'b1;
                    end
                    else
                    begin
                        if ((in_status & apds_pkg::PLAY_BITS) != 3'd0)
                        begin
                            m = m & ~apds_pkg::PLAY_BITS;
                            if (play_act_reg)
                            begin
                                q_plan.slots[apds_pkg::SLOT_PLAY_NOTE] = 1'b1;
                                if (p_fr != '0)
                                begin
                                    q_plan.slots[apds_pkg::SLOT_PLAY_ADDR] = 1'b1;
                                    q_plan.slots[apds_pkg::SLOT_PLAY_SIZE] = 1'b1;
                                    q_plan.play_buf2 = !in_status[apds_pkg::STAT_B1];
                                    m = m | apds_pkg::PLAY_BITS;
                                    play_ptr_next = p_new[apds_pkg::PTR_W-1:0];
                                end
                            end
                        end
                        if (in_status[apds_pkg::STAT_CAP])
                        begin
                            m = m & ~apds_pkg::CAP_BIT;
                            cap_ptr_next = fill_ptr_reg;
                            priming_next = 1'b0;
                            if (cap_act_reg)
                            begin
                                q_plan.slots[apds_pkg::SLOT_CAP_NOTE] = !priming_reg;
                                if ((c_fr != '0) && (cfg.cap_chan != 2'd0))
                                begin
                                    q_plan.slots[apds_pkg::SLOT_RD_ADDR]  = 1'b1;
                                    q_plan.slots[apds_pkg::SLOT_RD_START] = 1'b1;
                                    m = m | apds_pkg::CAP_BIT;
                                    fill_ptr_next = c_new[apds_pkg::PTR_W-1:0];
                                end
                            end
                        end
                        q_plan.slots[apds_pkg::SLOT_IRQ_FINAL] = 1'b1;
                        q_plan.irq_final = m;
                        mask_next = m;
                    end
                end
                apds_pkg::CMD_PLAY_START:
                begin
                    q_push        = 1'b1;
                    play_act_next = 1'b1;
                    mask_next     = mask_reg | apds_pkg::PLAY_BITS;
                    q_plan.slots[apds_pkg::SLOT_IRQ_FIRST] = 1'b1;
                    q_plan.irq_first = mask_next;
                end
                apds_pkg::CMD_PLAY_STOP:
                begin
                    q_push        = 1'b1;
                    play_act_next = 1'b0;
                    mask_next     = mask_reg & ~apds_pkg::PLAY_BITS;
                    q_plan.slots[apds_pkg::SLOT_IRQ_FIRST] = 1'b1;
                    q_plan.irq_first = mask_next;
                end
                apds_pkg::CMD_CAP_START:
                begin
                    q_push       = 1'b1;
                    cap_act_next = 1'b1;
                    priming_next = 1'b1;
                    mask_next    = mask_reg | apds_pkg::CAP_BIT;
                    q_plan.slots[apds_pkg::SLOT_IRQ_FIRST] = 1'b1;
                    q_plan.slots[apds_pkg::SLOT_RD_START]  = 1'b1;
                    q_plan.irq_first = mask_next;
                    q_plan.cap_fr    = '0;
                end
                apds_pkg::CMD_CAP_STOP:
                begin
                    q_push       = 1'b1;
                    cap_act_next = 1'b0;
                    mask_next    = mask_reg & ~apds_pkg::CAP_BIT;
                    q_plan.slots[apds_pkg::SLOT_IRQ_FIRST] = 1'b1;
                    q_plan.slots[apds_pkg::SLOT_RD_START]  = 1'b1;
                    q_plan.irq_first = mask_next;
                    q_plan.cap_fr    = '0;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
        q_plan.play_pos = play_ptr_next;
        q_plan.cap_pos  = cap_ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            play_act_reg <= 1'b0;
            cap_act_reg  <= 1'b0;
            priming_reg  <= 1'b0;
            play_ptr_reg <= '0;
            cap_ptr_reg  <= '0;
            fill_ptr_reg <= '0;
        end
        else
        begin
            mask_reg     <= mask_next;
            play_act_reg <= play_act_next;
            cap_act_reg  <= cap_act_next;
            priming_reg  <= priming_next;
            play_ptr_reg <= play_ptr_next;
            cap_ptr_reg  <= cap_ptr_next;
            fill_ptr_reg <= fill_ptr_next;
        end
    end

endmodule

// ===== rtl/apds_queue.sv =====
// Short plan queue between the front and back ends.
// Depends on apds_pkg.
module apds_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  apds_pkg::plan_t  push_plan,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output apds_pkg::plan_t  head_plan
);

    localparam int CNT_W = apds_pkg::QPTR_W + 1;

    apds_pkg::plan_t                 store [apds_pkg::QDEPTH];
    logic [apds_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [apds_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                count_reg, count_next;

    assign full       = (count_reg == CNT_W'(apds_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_plan  = store[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/apds_back.sv =====
// Back end: walks the slots of the plan at the queue head, one result
// a beat, into the output register. Depends on apds_pkg.
module apds_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  apds_pkg::cfg_t                  cfg,
    input  logic                            head_valid,
    input  apds_pkg::plan_t                 head_plan,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      out_kind,
    output logic [2:0]                      out_code,
    output logic [apds_pkg::ADDR_W-1:0]     out_value,
    output logic [apds_pkg::PTR_W-1:0]      out_play_pos,
    output logic [apds_pkg::PTR_W-1:0]      out_cap_pos,
    output logic                            out_last
);

    localparam int AW = apds_pkg::ADDR_W;

    logic [apds_pkg::NSLOTS-1:0]  done_reg, done_next;
    logic                         valid_reg, valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [2:0]                   code_reg, code_next;
    logic [AW-1:0]                value_reg, value_next;
    logic [apds_pkg::PTR_W-1:0]   ppos_reg, ppos_next, cpos_reg, cpos_next;
    logic                         last_reg, last_next;

    logic [apds_pkg::NSLOTS-1:0]  remain, sel_hot;
    logic [apds_pkg::SLOT_W-1:0]  sel;
    logic                         adv, emit, is_last;
    logic [AW-1:0]                cap_off, play_off, addr_base, addr_off, addr_sum;
    logic [apds_pkg::RSTART_W-1:0] rd_len;

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_code     = code_reg;
    assign out_value    = value_reg;
    assign out_play_pos = ppos_reg;
    assign out_cap_pos  = cpos_reg;
    assign out_last     = last_reg;

    // lowest pending slot
    always_comb
    begin
        remain = head_plan.slots & ~done_reg;
        sel    = '0;
        for (int i = apds_pkg::NSLOTS - 1; i >= 0; i--)
        begin
            if (remain[i])
            begin
                sel = apds_pkg::SLOT_W'(i);
            end
        end
        sel_hot = apds_pkg::NSLOTS'(1) << sel;
        is_last = ((remain & ~sel_hot) == '0);
    end

    // offsets: play pointer times four, capture pointer times 2*channels
    always_comb
    begin
        play_off = AW'({head_plan.play_ptr, 2'b00});
        cap_off  = (cfg.cap_chan[0] ? AW'({head_plan.cap_ptr, 1'b0}) : '0)
                 + (cfg.cap_chan[1] ? AW'({head_plan.cap_ptr, 2'b00}) : '0);
        rd_len   = (cfg.cap_chan[0] ? apds_pkg::RSTART_W'({head_plan.cap_fr, 1'b0}) : '0)
                 + (cfg.cap_chan[1] ? apds_pkg::RSTART_W'({head_plan.cap_fr, 2'b00}) : '0);
        if (sel == apds_pkg::SLOT_W'(apds_pkg::SLOT_PLAY_ADDR))
        begin
            addr_base = cfg.play_base;
            addr_off  = play_off;
        end
        else
        begin
            addr_base = cfg.cap_base;
            addr_off  = cap_off;
        end
        addr_sum = addr_base + addr_off;
    end

    assign adv  = !valid_reg || out_ready;
    assign emit = head_valid && adv;
    assign pop  = emit && is_last;

    // output register load
    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        code_next  = code_reg;
        value_next = value_reg;
        ppos_next  = ppos_reg;
        cpos_next  = cpos_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            done_next  = is_last ? '0 : (done_reg | sel_hot);
            ppos_next  = head_plan.play_pos;
            cpos_next  = head_plan.cap_pos;
            last_next  = is_last;
            kind_next  = apds_pkg::KIND_WRITE;
            code_next  = apds_pkg::REG_IRQ;
            value_next = '0;
            unique case (sel)
                apds_pkg::SLOT_W'(apds_pkg::SLOT_IRQ_FIRST):
                begin
                    value_next = AW'(head_plan.irq_first);
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_NONE):
                begin
                    kind_next = apds_pkg::KIND_NONE;
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_PLAY_ADDR):
                begin
                    code_next  = head_plan.play_buf2 ? apds_pkg::REG_B2_ADDR
                                                     : apds_pkg::REG_B1_ADDR;
                    value_next = addr_sum;
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_PLAY_SIZE):
                begin
                    code_next  = head_plan.play_buf2 ? apds_pkg::REG_B2_SIZE
                                                     : apds_pkg::REG_B1_SIZE;
                    value_next = AW'({head_plan.play_fr, 2'b00});
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_RD_ADDR):
                begin
                    code_next  = apds_pkg::REG_RD_ADDR;
                    value_next = addr_sum;
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_RD_START):
                begin
                    code_next  = apds_pkg::REG_RD_START;
                    value_next = AW'(rd_len);
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_IRQ_FINAL):
                begin
                    value_next = AW'(head_plan.irq_final);
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_PLAY_NOTE):
                begin
                    kind_next = apds_pkg::KIND_PLAY;
                end
                apds_pkg::SLOT_W'(apds_pkg::SLOT_CAP_NOTE):
                begin
                    kind_next = apds_pkg::KIND_CAP;
                end
                default:
                begin
                    kind_next = apds_pkg::KIND_NONE;
                end
            endcase
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        code_reg  <= code_next;
        value_reg <= value_next;
        ppos_reg  <= ppos_next;
        cpos_reg  <= cpos_next;
        last_reg  <= last_next;
    end

endmodule

// ===== rtl/audio_period_dma_sequencer_unit.sv =====
// Top level of the audio period DMA sequencer; instantiates apds_cfg_regs, apds_front,
// apds_queue and apds_back, all built on apds_pkg.
// Each event's plan is registered in the plan queue, then each result in the output register.
// Throughput: one event a cycle in while the two-entry plan queue has room; one result
// a cycle out while the receiver is ready, and an event gives 1 to 8 results.
// Reset empties the queue, clears state, pointers and out valid; capture channels to 2.
module audio_period_dma_sequencer_unit
#(
    parameter int MAX_RING_FRAMES = 16384
)
(
    input  logic         clk,
    input  logic         rst_n,
    // event input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [2:0] status_bits, [7:3] zero
    input  logic [2:0]   s_axis_tuser,   // [2:0] cmd
    // result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // [2:0] reg_code, [50:3] write_value,
                                         // [64:51] play_position,
                                         // [78:65] capture_position, [79] zero
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    apds_pkg::cfg_t                 cfg;
    apds_pkg::plan_t                push_plan, head_plan;
    logic                           push, pop, q_full, head_valid;
    logic [2:0]                     code;
    logic [apds_pkg::ADDR_W-1:0]    value;
    logic [apds_pkg::PTR_W-1:0]     ppos, cpos;

    // configuration registers
    apds_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // event classification and pointer state
    apds_front #(.MAX_RING_FRAMES(MAX_RING_FRAMES)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_status (s_axis_tdata[2:0]),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .q_push    (push),
        .q_plan    (push_plan)
    );

    // plan queue
    apds_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_plan  (push_plan),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_plan  (head_plan)
    );

    // result sequencing
    apds_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (head_valid),
        .head_plan    (head_plan),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (m_axis_tuser),
        .out_code     (code),
        .out_value    (value),
        .out_play_pos (ppos),
        .out_cap_pos  (cpos),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, cpos, ppos, value, code};

endmodule

// ===== verif/audio_period_dma_sequencer_unit_test.sv =====
// Testbench for the audio period DMA sequencer: trigger and interrupt events in,
// register-write and period beats out, each checked in order against a predictor.
// Depends on apds_pkg and audio_period_dma_sequencer_unit.
module audio_period_dma_sequencer_unit_test;

    localparam longint unsigned RING_LIMIT = 16384;
    localparam int SETTLE_CYCLES = 16;
    // codes the block ignores, and the code field on non-write beats
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
    localparam logic [2:0] REG_NONE       = 3'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_code;
        logic [47:0] value;
        logic [13:0] play_pos;
        logic [13:0] cap_pos;
        logic        last;
    } dma_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    // predictor copy of configuration
    logic [47:0] play_base_r   = '0;
    logic [13:0] play_period_r = '0;
    logic [14:0] play_ring_r   = '0;
    logic [47:0] cap_base_r    = '0;
    logic [14:0] cap_period_r  = '0;
    logic [14:0] cap_ring_r    = '0;
    logic [1:0]  cap_chan_r    = 2'd2;

    // predictor copy of state
    logic [2:0]  irq_mask_p    = '0;
    logic        play_run      = 1'b0;
    logic        cap_run       = 1'b0;
    logic        cap_first     = 1'b0;
    logic [13:0] play_ptr_p    = '0;
    logic [13:0] cap_ptr_p     = '0;
    logic [13:0] cap_ptr_ahead = '0;

    dma_beat_t event_beats[$];
    dma_beat_t expected_beats[$];
    int        errors    = 0;
    bit        gaps_on   = 1'b1;
    int        sink_hold = 0;

    audio_period_dma_sequencer_unit #(.MAX_RING_FRAMES(16384)) u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic longint unsigned clamp_ring(input logic [14:0] frames);
        return (frames > RING_LIMIT) ? RING_LIMIT : longint'(frames);
    endfunction

    // frames moved this period: the period, cut at the ring end
    function automatic longint unsigned span(input longint unsigned period,
                                             input longint unsigned ring,
                                             input logic [13:0] ptr);
        longint unsigned room;
        room = (ring > ptr) ? ring - ptr : 0;
        return (period > room) ? room : period;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [2:0] code,
                                 input logic [47:0] value);
        dma_beat_t b;
        b          = '0;
        b.kind     = kind;
        b.reg_code = code;
        b.value    = value;
        event_beats.push_back(b);
    endfunction

    function automatic void apply_config(input logic [2:0] idx, input logic [47:0] data);
        case (idx)
            apds_pkg::CFG_PLAY_BASE:   play_base_r   = data;
            apds_pkg::CFG_PLAY_PERIOD: play_period_r = data[13:0];
            apds_pkg::CFG_PLAY_BUFFER: play_ring_r   = data[14:0];
            apds_pkg::CFG_CAP_BASE:    cap_base_r    = data;
            apds_pkg::CFG_CAP_PERIOD:  cap_period_r  = data[14:0];
            apds_pkg::CFG_CAP_BUFFER:  cap_ring_r    = data[14:0];
            apds_pkg::CFG_CAP_CHAN:    cap_chan_r    = data[1:0];
            default: ;
        endcase
    endfunction

    // works out the beats one event causes and queues them
    function automatic void predict_event(input logic [2:0] cmd, input logic [2:0] status);
        longint unsigned ring;
        longint unsigned frames;
        longint unsigned bpf;
        logic            play_note;
        logic            cap_note;
        logic [47:0]     play_addr;
        play_note = 1'b0;
        cap_note  = 1'b0;
        event_beats.delete();
        case (cmd)
            apds_pkg::CMD_IRQ:
            begin
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, '0);
                if (status == 3'b000)
                begin
                    emit(apds_pkg::KIND_NONE, REG_NONE, '0);
                end
                else
                begin
                    // playback ping-pong service
                    if ((status & apds_pkg::PLAY_BITS) != 3'b000)
                    begin
                        irq_mask_p &= ~apds_pkg::PLAY_BITS;
                        if (play_run)
                        begin
                            ring      = clamp_ring(play_ring_r);
                            frames    = span(play_period_r, ring, play_ptr_p);
                            play_note = 1'b1;
                            if (frames != 0)
                            begin
                                play_addr = play_base_r + {play_ptr_p, 2'b00};
                                if (status[apds_pkg::STAT_B1])
                                begin
                                    emit(apds_pkg::KIND_WRITE, apds_pkg::REG_B1_ADDR, play_addr);
                                    emit(apds_pkg::KIND_WRITE, apds_pkg::REG_B1_SIZE,
                                         48'(frames * 4));
                                end
                                else
                                begin
                                    emit(apds_pkg::KIND_WRITE, apds_pkg::REG_B2_ADDR, play_addr);
                                    emit(apds_pkg::KIND_WRITE, apds_pkg::REG_B2_SIZE,
                                         48'(frames * 4));
                                end
                                irq_mask_p |= apds_pkg::PLAY_BITS;
                                play_ptr_p = 14'((play_ptr_p + frames) % ring);
                            end
                        end
                    end
                    // capture service; reported pointer lags one period
                    if (status[apds_pkg::STAT_CAP])
                    begin
                        irq_mask_p &= ~apds_pkg::CAP_BIT;
                        cap_ptr_p = cap_ptr_ahead;
                        if (cap_run)
                        begin
                            bpf      = 2 * cap_chan_r;
                            ring     = clamp_ring(cap_ring_r);
                            frames   = span(cap_period_r, ring, cap_ptr_p);
                            cap_note = 1'b1;
                            if (frames != 0 && bpf != 0)
                            begin
                                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_RD_ADDR,
                                     48'(cap_base_r + cap_ptr_p * bpf));
                                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_RD_START,
                                     48'(frames * bpf));
                                irq_mask_p |= apds_pkg::CAP_BIT;
                                cap_ptr_ahead = 14'((cap_ptr_ahead + frames) % ring);
                            end
                        end
                        if (cap_first)
                        begin
                            cap_note  = 1'b0;
                            cap_first = 1'b0;
                        end
                    end
                    emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, 48'(irq_mask_p));
                    if (play_note)
                        emit(apds_pkg::KIND_PLAY, REG_NONE, '0);
                    if (cap_note)
                        emit(apds_pkg::KIND_CAP, REG_NONE, '0);
                end
            end
            apds_pkg::CMD_PLAY_START:
            begin
                play_run   = 1'b1;
                irq_mask_p |= apds_pkg::PLAY_BITS;
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, 48'(irq_mask_p));
            end
            apds_pkg::CMD_PLAY_STOP:
            begin
                irq_mask_p &= ~apds_pkg::PLAY_BITS;
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, 48'(irq_mask_p));
                play_run = 1'b0;
            end
            apds_pkg::CMD_CAP_START:
            begin
                cap_run    = 1'b1;
                cap_first  = 1'b1;
                irq_mask_p |= apds_pkg::CAP_BIT;
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, 48'(irq_mask_p));
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_RD_START, '0);
            end
            apds_pkg::CMD_CAP_STOP:
            begin
                cap_run    = 1'b0;
                irq_mask_p &= ~apds_pkg::CAP_BIT;
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_IRQ, 48'(irq_mask_p));
                emit(apds_pkg::KIND_WRITE, apds_pkg::REG_RD_START, '0);
            end
            default: ;
        endcase
        // positions are those after the whole event
        foreach (event_beats[i])
        begin
            event_beats[i].play_pos = play_ptr_p;
            event_beats[i].cap_pos  = cap_ptr_p;
            event_beats[i].last     = (i == event_beats.size() - 1);
            expected_beats.push_back(event_beats[i]);
        end
    endfunction

    // ---------------- monitors and checker ----------------

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            apply_config(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_event(s_axis_tuser, s_axis_tdata[2:0]);
    end

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : beat_check
        dma_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, got tuser %0h tdata %0h tlast %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = expected_beats.pop_front();
                compare_field("kind", want.kind, m_axis_tuser);
                compare_field("reg_code", want.reg_code, m_axis_tdata[2:0]);
                compare_field("write_value", want.value, m_axis_tdata[50:3]);
                compare_field("play_position", want.play_pos, m_axis_tdata[64:51]);
                compare_field("capture_position", want.cap_pos, m_axis_tdata[78:65]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // result side: random stalls per beat, plus a long hold when asked
    initial
    begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ---------------- drivers ----------------

    // valid is left high on return so back-to-back events need no extra edge
    task automatic send_event(input logic [2:0] cmd, input logic [2:0] status);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b00000, status};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [47:0] play_base, input logic [47:0] play_period,
                              input logic [47:0] play_ring, input logic [47:0] cap_base,
                              input logic [47:0] cap_period, input logic [47:0] cap_ring,
                              input logic [47:0] cap_chan);
        write_reg(apds_pkg::CFG_PLAY_BASE, play_base);
        write_reg(apds_pkg::CFG_PLAY_PERIOD, play_period);
        write_reg(apds_pkg::CFG_PLAY_BUFFER, play_ring);
        write_reg(apds_pkg::CFG_CAP_BASE, cap_base);
        write_reg(apds_pkg::CFG_CAP_PERIOD, cap_period);
        write_reg(apds_pkg::CFG_CAP_BUFFER, cap_ring);
        write_reg(apds_pkg::CFG_CAP_CHAN, cap_chan);
    endtask

    // drop valid, wait for every expected beat, then let an ignored event drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom, $urandom});
    endfunction

    // mostly short lengths, with zero and the field maximum now and then
    function automatic logic [14:0] pick_frames(input logic [14:0] top);
        case ($urandom_range(0, 7))
            0:       return 15'd0;
            1:       return top;
            2:       return 15'($urandom_range(1, top));
            default: return 15'($urandom_range(1, 96));
        endcase
    endfunction

    function automatic logic [1:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       return 2'd0;
            1:       return 2'd3;
            default: return 2'($urandom_range(1, 2));
        endcase
    endfunction

    // ---------------- tests ----------------

    // reset configuration: zero rings, so no transfers, only register writes and notices
    task automatic test_reset_defaults();
        send_event(apds_pkg::CMD_CAP_START, 3'b111);
        send_event(apds_pkg::CMD_PLAY_START, 3'b000);
        send_event(apds_pkg::CMD_IRQ, 3'b111);
        settle();
    endtask

    task automatic test_directed_ops();
        set_config(48'h0000_0001_0000, 64, 256, 48'h0000_0002_0000, 32, 128, 2);
        send_event(apds_pkg::CMD_IRQ, 3'b000);
        send_event(apds_pkg::CMD_IRQ, 3'b001);
        send_event(apds_pkg::CMD_IRQ, 3'b010);
        send_event(apds_pkg::CMD_IRQ, 3'b011);
        send_event(apds_pkg::CMD_PLAY_START, 3'b000);
        send_event(apds_pkg::CMD_CAP_START, 3'b000);
        // first capture period after a start stays silent
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        send_event(apds_pkg::CMD_IRQ, 3'b110);
        send_event(apds_pkg::CMD_IRQ, 3'b111);
        send_event(apds_pkg::CMD_CAP_STOP, 3'b000);
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        send_event(apds_pkg::CMD_PLAY_STOP, 3'b000);
        send_event(apds_pkg::CMD_IRQ, 3'b011);
        send_event(CMD_RSVD_FIRST, 3'b101);
        send_event(3'd6, 3'b010);
        send_event(CMD_RSVD_LAST, 3'b111);
        send_event(apds_pkg::CMD_PLAY_STOP, 3'b000);
        settle();
    endtask

    task automatic test_ring_edges();
        // oversized rings, address wrap at 48 bits, three-channel capture
        set_config(48'hFFFF_FFFF_FFF0, 8192, 48'h7FFF, 48'hFFFF_FFFF_FFFF, 48'h7FFF, 16384, 3);
        send_event(apds_pkg::CMD_PLAY_START, 3'b000);
        send_event(apds_pkg::CMD_CAP_START, 3'b000);
        repeat (3) send_event(apds_pkg::CMD_IRQ, 3'b111);
        settle();
        // zero period and zero channels give zero transfers
        set_config(48'hFFFF_FFFF_FFF0, 0, 48'h7FFF, 48'hFFFF_FFFF_FFFF, 100, 16384, 0);
        send_event(apds_pkg::CMD_IRQ, 3'b111);
        settle();
        // playback pointer left past a shrunken ring end
        set_config(48'h0, 300, 100, 48'h0000_0000_1000, 5000, 16384, 1);
        send_event(apds_pkg::CMD_IRQ, 3'b011);
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        settle();
        // capture pointer past the end after the ring shrinks
        write_reg(apds_pkg::CFG_CAP_BUFFER, 3000);
        send_event(apds_pkg::CMD_IRQ, 3'b100);
        settle();
    endtask

    // long receiver hold while events keep coming, so the input backs up
    task automatic test_output_stall();
        set_config(48'h0000_0400_0000, 16, 64, 48'h0000_0800_0000, 8, 48, 2);
        gaps_on   = 1'b0;
        sink_hold = 300;
        send_event(apds_pkg::CMD_PLAY_START, 3'b000);
        send_event(apds_pkg::CMD_CAP_START, 3'b000);
        repeat (14) send_event(apds_pkg::CMD_IRQ, 3'b111);
        settle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int remaining;
        int phase;
        int burst;
        int pick;
        remaining = 110;
        phase     = 0;
        while (remaining > 0)
        begin
            set_config(rand_addr(), 48'(pick_frames(15'h3FFF)), 48'(pick_frames(15'h7FFF)),
                       rand_addr(), 48'(pick_frames(15'h7FFF)), 48'(pick_frames(15'h7FFF)),
                       48'(pick_chan()));
            // every fourth phase runs without gaps on either side
            gaps_on = (phase % 4) != 3;
            send_event(apds_pkg::CMD_PLAY_START, 3'($urandom_range(0, 7)));
            send_event(apds_pkg::CMD_CAP_START, 3'($urandom_range(0, 7)));
            burst     = $urandom_range(15, 35);
            remaining = remaining - burst - 2;
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    send_event(apds_pkg::CMD_IRQ, 3'($urandom_range(1, 7)));
                else if (pick < 68)
                    send_event(apds_pkg::CMD_IRQ, 3'b000);
                else if (pick < 75)
                    send_event(apds_pkg::CMD_PLAY_START, 3'($urandom_range(0, 7)));
                else if (pick < 82)
                    send_event(apds_pkg::CMD_PLAY_STOP, 3'($urandom_range(0, 7)));
                else if (pick < 88)
                    send_event(apds_pkg::CMD_CAP_START, 3'($urandom_range(0, 7)));
                else if (pick < 94)
                    send_event(apds_pkg::CMD_CAP_STOP, 3'($urandom_range(0, 7)));
                else
                    send_event(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
                               3'($urandom_range(0, 7)));
            end
            settle();
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= apds_pkg::CMD_IRQ;
        cfg_valid     <= 1'b0;
        cfg_index     <= apds_pkg::CFG_PLAY_BASE;
        cfg_data      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_ops();
        test_ring_edges();
        test_output_stall();
        test_random_traffic();
        settle();

        if (errors == 0 && expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
